/* src/rgb_to_hsv_converter_top_assert.svh */
// Assertion macros for the RGB to HSV converter top level.
// Expects clk and arst_n in the scope of use.
`ifndef RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define RHC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rhc_pkg.sv */
// rhc_pkg: widths, word types and divider cell word for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int COMP_BITS  = 16;
	localparam int QUOT_BITS  = COMP_BITS + 1;
	localparam int HDIV_BITS  = COMP_BITS + 3;
	localparam int CELL_COUNT = QUOT_BITS;

	typedef struct packed {
		logic [COMP_BITS-1:0] alpha_in;
		logic [COMP_BITS-1:0] red;
		logic [COMP_BITS-1:0] green;
		logic [COMP_BITS-1:0] blue;
		logic                 last_pixel;
	} pixel_in_t;

	typedef struct packed {
		logic [COMP_BITS-1:0] alpha_out;
		logic [COMP_BITS-1:0] hue;
		logic [COMP_BITS-1:0] saturation;
		logic [COMP_BITS-1:0] brightness;
		logic                 last_out;
	} pixel_out_t;

	typedef struct packed {
		logic [COMP_BITS-1:0] alpha;
		logic                 last;
		logic                 grey;
		logic [COMP_BITS-1:0] vmax;
		logic [COMP_BITS-1:0] sat_rem;
		logic [COMP_BITS:0]   sat_low;
		logic [COMP_BITS:0]   sat_q;
		logic [HDIV_BITS-1:0] hue_rem;
		logic [HDIV_BITS-1:0] hue_div;
		logic [COMP_BITS:0]   hue_low;
		logic [COMP_BITS:0]   hue_q;
	} div_word_t;

endpackage

/* src/rgb_to_hsv_converter_top.sv */
// rgb_to_hsv_converter_top: RGB to HSV pixel converter over a chain of divider cells.
// One word per cycle while the skid entry is not full.
// Words pass through two front stages, the 17-cell division chain and the output register.
// Reset clears all valid bits; input is taken right after reset. Stall input freezes
// the chain once the skid entry is full. Depends on rhc_pkg, rhc_prep, rhc_div_cell,
// rhc_skid and rgb_to_hsv_converter_top_assert.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_top_assert.svh"

module rgb_to_hsv_converter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  rhc_pkg::pixel_in_t  pix,
	output logic                hsv_valid,
	input  logic                hsv_stall,
	output rhc_pkg::pixel_out_t hsv
);

	localparam int B = rhc_pkg::COMP_BITS;
	localparam int N = rhc_pkg::CELL_COUNT;

	logic                full;
	logic                en;
	logic                chain_valid [0:N];
	rhc_pkg::div_word_t  chain_word [0:N];
	rhc_pkg::pixel_out_t res;

	assign en        = !full;
	assign pix_stall = full;

	rhc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pix_valid (pix_valid),
		.pix       (pix),
		.valid     (chain_valid[0]),
		.word      (chain_word[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (chain_valid[i]),
			.up_word  (chain_word[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_word  (chain_word[i+1])
		);
	end

	always_comb begin
		res.alpha_out  = chain_word[N].alpha;
		res.hue        = chain_word[N].grey ? '0 : chain_word[N].hue_q[B-1:0];
		res.saturation = chain_word[N].grey ? '0 : chain_word[N].sat_q[B-1:0];
		res.brightness = chain_word[N].vmax;
		res.last_out   = chain_word[N].last;
	end

	rhc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && chain_valid[N]),
		.push_word (res),
		.stall     (hsv_stall),
		.full      (full),
		.valid     (hsv_valid),
		.word      (hsv)
	);

	`RHC_ASSERT_IMP(a_skid_behind_out, pix_stall, hsv_valid, "skid full with empty output")
	`RHC_ASSERT_IMP(a_stall_cause, $rose(pix_stall), $past(hsv_valid && hsv_stall), "no cause")
	`RHC_ASSERT_NXT(a_skid_drain, pix_stall && !hsv_stall, !pix_stall, "skid did not drain")
	`RHC_ASSERT_IMP(a_grey_hue, hsv_valid && hsv.saturation == '0, hsv.hue == '0, "grey word with hue")

endmodule

/* src/rhc_prep.sv */
// rhc_prep: two front stages, max/min select then chroma and divider setup.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                pix_valid,
	input  rhc_pkg::pixel_in_t  pix,
	output logic                valid,
	output rhc_pkg::div_word_t  word
);

	localparam int B = rhc_pkg::COMP_BITS;
	localparam int H = rhc_pkg::HDIV_BITS;

	typedef enum logic [2:0] {
		SEL_RED   = 3'b001,
		SEL_GREEN = 3'b010,
		SEL_BLUE  = 3'b100
	} max_sel_t;

	max_sel_t        sel_c;
	logic [B-1:0]    vmax_c;
	logic [B-1:0]    vmin_c;
	logic [B:0]      n_c;

	logic            valid_s1;
	logic [B-1:0]    alpha_s1;
	logic            last_s1;
	logic [B-1:0]    vmax_s1;
	logic [B-1:0]    vmin_s1;
	logic [B:0]      n_s1;
	max_sel_t        sel_s1;

	logic [B-1:0]    chroma;
	logic [H-1:0]    kc;
	logic [H-1:0]    m;
	logic [H-1:0]    six_c;
	logic [2*B-1:0]  x;

	logic               valid_s2;
	rhc_pkg::div_word_t word_s2;

	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sel_c  = SEL_RED;
			vmax_c = pix.red;
		end else if (pix.green >= pix.blue) begin
			sel_c  = SEL_GREEN;
			vmax_c = pix.green;
		end else begin
			sel_c  = SEL_BLUE;
			vmax_c = pix.blue;
		end
		vmin_c = pix.red;
		if (pix.green < vmin_c) vmin_c = pix.green;
		if (pix.blue < vmin_c) vmin_c = pix.blue;
		unique case (sel_c)
			SEL_RED:   n_c = {1'b0, pix.green} - {1'b0, pix.blue};
			SEL_GREEN: n_c = {1'b0, pix.blue} - {1'b0, pix.red};
			SEL_BLUE:  n_c = {1'b0, pix.red} - {1'b0, pix.green};
			default:   n_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s1 <= pix.alpha_in;
			last_s1  <= pix.last_pixel;
			vmax_s1  <= vmax_c;
			vmin_s1  <= vmin_c;
			n_s1     <= n_c;
			sel_s1   <= sel_c;
		end
	end

	always_comb begin
		chroma = vmax_s1 - vmin_s1;
		six_c  = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
		unique case (sel_s1)
			SEL_RED:   kc = six_c;
			SEL_GREEN: kc = {2'b00, chroma, 1'b0};
			SEL_BLUE:  kc = {1'b0, chroma, 2'b00};
			default:   kc = '0;
		endcase
		m = kc + {{(H-B-1){n_s1[B]}}, n_s1};
		x = {chroma, {B{1'b0}}} - {{B{1'b0}}, chroma};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2.alpha   <= alpha_s1;
			word_s2.last    <= last_s1;
			word_s2.grey    <= (chroma == '0);
			word_s2.vmax    <= vmax_s1;
			word_s2.sat_rem <= {1'b0, x[2*B-1:B+1]};
			word_s2.sat_low <= x[B:0];
			word_s2.sat_q   <= '0;
			word_s2.hue_rem <= {1'b0, m[H-1:1]};
			word_s2.hue_div <= six_c;
			word_s2.hue_low <= {m[0], {B{1'b0}}};
			word_s2.hue_q   <= '0;
		end
	end

	assign valid = valid_s2;
	assign word  = word_s2;

endmodule

/* src/rhc_div_cell.sv */
// rhc_div_cell: one restoring-division step for saturation and hue, registered.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               up_valid,
	input  rhc_pkg::div_word_t up_word,
	output logic               dn_valid,
	output rhc_pkg::div_word_t dn_word
);

	localparam int B = rhc_pkg::COMP_BITS;
	localparam int H = rhc_pkg::HDIV_BITS;

	logic [B:0]         sat_try;
	logic [B:0]         sat_dv;
	logic [B:0]         sat_diff;
	logic               sat_bit;
	logic [H:0]         hue_try;
	logic [H:0]         hue_dv;
	logic [H:0]         hue_diff;
	logic               hue_bit;
	rhc_pkg::div_word_t nxt;

	logic               valid_q;
	rhc_pkg::div_word_t word_q;

	always_comb begin
		sat_try  = {up_word.sat_rem, up_word.sat_low[B]};
		sat_dv   = {1'b0, up_word.vmax};
		sat_diff = sat_try - sat_dv;
		sat_bit  = (sat_try >= sat_dv);
		hue_try  = {up_word.hue_rem, up_word.hue_low[B]};
		hue_dv   = {1'b0, up_word.hue_div};
		hue_diff = hue_try - hue_dv;
		hue_bit  = (hue_try >= hue_dv);

		nxt         = up_word;
		nxt.sat_rem = sat_bit ? sat_diff[B-1:0] : sat_try[B-1:0];
		nxt.sat_low = {up_word.sat_low[B-1:0], 1'b0};
		nxt.sat_q   = {up_word.sat_q[B-1:0], sat_bit};
		nxt.hue_rem = hue_bit ? hue_diff[H-1:0] : hue_try[H-1:0];
		nxt.hue_low = {up_word.hue_low[B-1:0], 1'b0};
		nxt.hue_q   = {up_word.hue_q[B-1:0], hue_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;

endmodule

/* src/rhc_skid.sv */
// rhc_skid: output register with one skid entry; full freezes the pipeline.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rhc_pkg::pixel_out_t push_word,
	input  logic                stall,
	output logic                full,
	output logic                valid,
	output rhc_pkg::pixel_out_t word
);

	logic                out_valid_q;
	rhc_pkg::pixel_out_t out_word_q;
	logic                skid_valid_q;
	rhc_pkg::pixel_out_t skid_word_q;
	logic                take;

	assign take = out_valid_q && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_word_q <= skid_word_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_word_q <= push_word;
			end else begin
				out_word_q <= push_word;
			end
		end
	end

	assign full  = skid_valid_q;
	assign valid = out_valid_q;
	assign word  = out_word_q;

endmodule
